>>> design/vector3_fixed_point_alu_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3D vector fixed-point unit.
// Bodies are empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_FIXED_POINT_ALU_TOP_MACROS_SVH
`define VECTOR3_FIXED_POINT_ALU_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define VFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vector unit assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vector unit assertion failed");

`else

`define VFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/vfa_pkg.sv
// ----------------------------------------------------------------------------
// vfa_pkg
// Types, operation codes and helper functions of the 3D vector unit.
// ----------------------------------------------------------------------------
package vfa_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int WORD_W            = 32;
    localparam int EPS_W             = 16;
    localparam int OP_W              = 4;
    localparam int ROOT_W            = 32;
    localparam int IN_DATA_W         = 192;
    localparam int OUT_DATA_W        = 136;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic signed [67:0] SAT_HI = 68'sh7FFF_FFFF;
    localparam logic signed [67:0] SAT_LO = -68'sh8000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_DOT       = 4'd2,
        OP_CROSS     = 4'd3,
        OP_LENGTH    = 4'd4,
        OP_NORMALIZE = 4'd5,
        OP_ORTHO     = 4'd6,
        OP_LARGEST   = 4'd7,
        OP_SCALE     = 4'd8
    } op_t;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t [2:0] vec_t;

    typedef struct packed {
        op_t  op;
        vec_t a;
        vec_t b;
    } item_t;

    typedef struct packed {
        vec_t       r;
        word_t      scalar;
        logic [1:0] axis;
        logic       sat;
    } result_t;

    // Payload that travels down the whole pipeline.
    typedef struct packed {
        op_t     op;
        vec_t    v;
        result_t res;
    } sqc_t;

    typedef struct packed {
        sqc_t c;
        vec_t a;
        vec_t b;
    } front_t;

    typedef struct packed {
        sqc_t        c;
        logic [63:0] sumsq;
    } mid_t;

    typedef struct packed {
        sqc_t              c;
        logic [ROOT_W-1:0] len;
    } root_t;

    typedef struct packed {
        word_t val;
        logic  clip;
    } sat_t;

    // Clip a wide signed value to the 32-bit range.
    function automatic sat_t sat_word(input logic signed [67:0] x);
        sat_t s;
        if (x > SAT_HI) begin
            s.val  = 32'sh7FFF_FFFF;
            s.clip = 1'b1;
        end else if (x < SAT_LO) begin
            s.val  = 32'sh8000_0000;
            s.clip = 1'b1;
        end else begin
            s.val  = x[WORD_W-1:0];
            s.clip = 1'b0;
        end
        return s;
    endfunction

    // Magnitude of a word; the most negative value gives 2^31.
    function automatic logic [WORD_W-1:0] mag_word(input word_t w);
        logic [WORD_W-1:0] u;
        u = w;
        return u[WORD_W-1] ? (~u + 32'd1) : u;
    endfunction

    // Index of the largest absolute component; ties go to the higher index.
    function automatic logic [1:0] largest_axis(input vec_t v);
        logic [WORD_W-1:0] mx;
        logic [WORD_W-1:0] my;
        logic [WORD_W-1:0] mz;
        logic [1:0]        k;
        mx = mag_word(v[0]);
        my = mag_word(v[1]);
        mz = mag_word(v[2]);
        if (mx > my) begin
            k = (mx > mz) ? AXIS_X : AXIS_Z;
        end else begin
            k = (my > mz) ? AXIS_Y : AXIS_Z;
        end
        return k;
    endfunction

endpackage

>>> design/vfa_front.sv
// ----------------------------------------------------------------------------
// vfa_front
// Input register and first compute stage: add, subtract, largest axis and
// the ortho cross product against a unit axis.
// ----------------------------------------------------------------------------
module vfa_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  vfa_pkg::item_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output vfa_pkg::front_t out_data
);
    import vfa_pkg::*;

    logic   s0_vld_reg;
    item_t  s0_reg;
    logic   s1_vld_reg;
    front_t s1_reg;
    front_t s1_next;

    logic   adv0;
    logic   adv1;

    sat_t       add_s [3];
    sat_t       sub_s [3];
    sat_t       neg_s [3];
    logic [1:0] axis;
    logic [1:0] k_axis;
    vec_t       ortho_v;
    logic       ortho_clip;

    // Each stage moves when it is empty or the next one moves.
    assign adv1     = !s1_vld_reg || out_ready;
    assign adv0     = !s0_vld_reg || adv1;
    assign in_ready = adv0;

    // Lane arithmetic on the registered beat.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            add_s[i] = sat_word(68'(s0_reg.a[i]) + 68'(s0_reg.b[i]));
            sub_s[i] = sat_word(68'(s0_reg.a[i]) - 68'(s0_reg.b[i]));
            neg_s[i] = sat_word(-68'(s0_reg.a[i]));
        end
    end

    // Cross with the unit axis one below the largest, wrapping to z.
    always_comb begin
        axis   = largest_axis(s0_reg.a);
        k_axis = (axis == AXIS_X) ? AXIS_Z : axis - 2'd1;
        unique case (k_axis)
            AXIS_X: begin
                ortho_v    = {neg_s[1].val, s0_reg.a[2], 32'sd0};
                ortho_clip = neg_s[1].clip;
            end
            AXIS_Y: begin
                ortho_v    = {s0_reg.a[0], 32'sd0, neg_s[2].val};
                ortho_clip = neg_s[2].clip;
            end
            default: begin
                ortho_v    = {32'sd0, neg_s[0].val, s0_reg.a[1]};
                ortho_clip = neg_s[0].clip;
            end
        endcase
    end

    // Result selection by operation.
    always_comb begin
        s1_next      = '0;
        s1_next.a    = s0_reg.a;
        s1_next.b    = s0_reg.b;
        s1_next.c.op = s0_reg.op;
        s1_next.c.v  = s0_reg.a;
        unique case (s0_reg.op)
            OP_ADD: begin
                for (int i = 0; i < 3; i++) begin
                    s1_next.c.res.r[i] = add_s[i].val;
                end
                s1_next.c.res.sat = add_s[0].clip | add_s[1].clip | add_s[2].clip;
            end
            OP_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    s1_next.c.res.r[i] = sub_s[i].val;
                end
                s1_next.c.res.sat = sub_s[0].clip | sub_s[1].clip | sub_s[2].clip;
            end
            OP_LARGEST: begin
                s1_next.c.res.axis = axis;
            end
            OP_ORTHO: begin
                s1_next.c.v       = ortho_v;
                s1_next.c.res.sat = ortho_clip;
            end
            default: begin
            end
        endcase
    end

    // Stage registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
        end else begin
            if (adv0) begin
                s0_vld_reg <= in_valid;
            end
            if (adv1) begin
                s1_vld_reg <= s0_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv0) begin
            s0_reg <= in_data;
        end
        if (adv1) begin
            s1_reg <= s1_next;
        end
    end

    assign out_valid = s1_vld_reg;
    assign out_data  = s1_reg;

endmodule

>>> design/vfa_mult.sv
// ----------------------------------------------------------------------------
// vfa_mult
// Six shared 32x32 multipliers, then the sums for dot, cross, scale and
// the sum of squares used for length, normalize and ortho.
// ----------------------------------------------------------------------------
module vfa_mult #(
    parameter int FRAC_BITS = vfa_pkg::FRAC_BITS_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  vfa_pkg::front_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output vfa_pkg::mid_t   out_data
);
    import vfa_pkg::*;

    word_t              pl [6];
    word_t              pr [6];
    logic signed [63:0] prod_next [6];
    logic signed [63:0] prod_reg  [6];
    sqc_t               p_c_reg;
    logic               p_vld_reg;

    mid_t               s_next;
    mid_t               s_reg;
    logic               s_vld_reg;

    logic               adv_p;
    logic               adv_s;

    logic signed [67:0] dot_w;
    logic signed [67:0] cross_w [3];
    logic signed [67:0] scale_w [3];
    sat_t               dot_s;
    sat_t               cross_s [3];
    sat_t               scale_s [3];

    assign adv_s    = !s_vld_reg || out_ready;
    assign adv_p    = !p_vld_reg || adv_s;
    assign in_ready = adv_p;

    // Operand selection for the multipliers.
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            pl[i] = '0;
            pr[i] = '0;
        end
        unique case (in_data.c.op) inside
            OP_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    pl[i] = in_data.a[i];
                    pr[i] = in_data.b[i];
                end
            end
            OP_CROSS: begin
                pl[0] = in_data.a[1]; pr[0] = in_data.b[2];
                pl[1] = in_data.a[2]; pr[1] = in_data.b[1];
                pl[2] = in_data.a[2]; pr[2] = in_data.b[0];
                pl[3] = in_data.a[0]; pr[3] = in_data.b[2];
                pl[4] = in_data.a[0]; pr[4] = in_data.b[1];
                pl[5] = in_data.a[1]; pr[5] = in_data.b[0];
            end
            OP_LENGTH, OP_NORMALIZE, OP_ORTHO: begin
                for (int i = 0; i < 3; i++) begin
                    pl[i] = in_data.c.v[i];
                    pr[i] = in_data.c.v[i];
                end
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    pl[i] = in_data.a[i];
                    pr[i] = in_data.b[0];
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 6; i++) begin
            prod_next[i] = pl[i] * pr[i];
        end
    end

    // Exact sums, floor shift and clipping.
    always_comb begin
        dot_w      = (68'(prod_reg[0]) + 68'(prod_reg[1]) + 68'(prod_reg[2])) >>> FRAC_BITS;
        cross_w[0] = (68'(prod_reg[0]) - 68'(prod_reg[1])) >>> FRAC_BITS;
        cross_w[1] = (68'(prod_reg[2]) - 68'(prod_reg[3])) >>> FRAC_BITS;
        cross_w[2] = (68'(prod_reg[4]) - 68'(prod_reg[5])) >>> FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            scale_w[i] = 68'(prod_reg[i]) >>> FRAC_BITS;
            cross_s[i] = sat_word(cross_w[i]);
            scale_s[i] = sat_word(scale_w[i]);
        end
        dot_s = sat_word(dot_w);

        s_next       = '0;
        s_next.c     = p_c_reg;
        s_next.sumsq = 64'(prod_reg[0]) + 64'(prod_reg[1]) + 64'(prod_reg[2]);
        unique case (p_c_reg.op)
            OP_DOT: begin
                s_next.c.res.scalar = dot_s.val;
                s_next.c.res.sat    = dot_s.clip;
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    s_next.c.res.r[i] = cross_s[i].val;
                end
                s_next.c.res.sat = cross_s[0].clip | cross_s[1].clip | cross_s[2].clip;
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    s_next.c.res.r[i] = scale_s[i].val;
                end
                s_next.c.res.sat = scale_s[0].clip | scale_s[1].clip | scale_s[2].clip;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
        end else begin
            if (adv_p) begin
                p_vld_reg <= in_valid;
            end
            if (adv_s) begin
                s_vld_reg <= p_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_p) begin
            p_c_reg <= in_data.c;
            for (int i = 0; i < 6; i++) begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (adv_s) begin
            s_reg <= s_next;
        end
    end

    assign out_valid = s_vld_reg;
    assign out_data  = s_reg;

endmodule

>>> design/vfa_sqrt.sv
// ----------------------------------------------------------------------------
// vfa_sqrt
// Pipelined integer square root, one result bit per stage, MSB first.
// ----------------------------------------------------------------------------
module vfa_sqrt (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  vfa_pkg::mid_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output vfa_pkg::root_t out_data
);
    import vfa_pkg::*;

    logic              vld_reg  [ROOT_W];
    sqc_t              c_reg    [ROOT_W];
    logic [63:0]       rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic              adv      [ROOT_W+1];

    assign adv[ROOT_W] = out_ready;
    assign in_ready    = adv[0];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_step
        localparam int J = ROOT_W - 1 - s;

        logic              vld_in;
        sqc_t              c_in;
        logic [63:0]       rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [65:0]       trial;
        logic              take;

        if (s == 0) begin : g_first
            assign vld_in  = in_valid;
            assign c_in    = in_data.c;
            assign rem_in  = in_data.sumsq;
            assign root_in = '0;
        end else begin : g_rest
            assign vld_in  = vld_reg[s-1];
            assign c_in    = c_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        // Try setting bit J: cost is 2*root*2^J + 2^(2J).
        assign trial  = (66'(root_in) << (J + 1)) | (66'(1) << (2 * J));
        assign take   = {2'b00, rem_in} >= trial;
        assign adv[s] = !vld_reg[s] || adv[s+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (adv[s]) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[s]) begin
                c_reg[s] <= c_in;
                if (take) begin
                    rem_reg[s]  <= rem_in - trial[63:0];
                    root_reg[s] <= root_in | (ROOT_W'(1) << J);
                end else begin
                    rem_reg[s]  <= rem_in;
                    root_reg[s] <= root_in;
                end
            end
        end
    end

    assign out_valid    = vld_reg[ROOT_W-1];
    assign out_data.c   = c_reg[ROOT_W-1];
    assign out_data.len = root_reg[ROOT_W-1];

endmodule

>>> design/vfa_div.sv
// ----------------------------------------------------------------------------
// vfa_div
// Length clipping, epsilon check and a pipelined restoring divider per lane
// for normalize and ortho, followed by the output register.
// ----------------------------------------------------------------------------
`include "vector3_fixed_point_alu_top_macros.svh"

module vfa_div #(
    parameter int FRAC_BITS = vfa_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [vfa_pkg::EPS_W-1:0]   length_epsilon,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  vfa_pkg::root_t              in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output vfa_pkg::result_t            out_data
);
    import vfa_pkg::*;

    localparam int NSTEP = FRAC_BITS + 1;
    localparam int RW    = WORD_W + FRAC_BITS + 1;

    typedef struct packed {
        op_t               op;
        vec_t              v;
        result_t           res;
        logic [ROOT_W-1:0] len;
        logic              bypass;
    } dvc_t;

    dvc_t              prep_next;
    dvc_t              prep_reg;
    logic              prep_vld_reg;
    logic [WORD_W-1:0] mag_reg [3];
    logic              adv_prep;

    logic              vld_reg [NSTEP];
    dvc_t              c_reg   [NSTEP];
    logic [RW-1:0]     rem_reg [NSTEP][3];
    logic [NSTEP-1:0]  q_reg   [NSTEP][3];
    logic              adv     [NSTEP+1];

    result_t           out_next;
    result_t           out_reg;
    op_t               out_op_reg;
    logic              out_valid_reg;
    logic              adv_out;
    word_t             qw [3];

    assign adv_out    = !out_valid_reg || out_ready;
    assign adv[NSTEP] = adv_out;
    assign adv_prep   = !prep_vld_reg || adv[0];
    assign in_ready   = adv_prep;

    // Length result and the unchanged-vector decision.
    always_comb begin
        prep_next        = '0;
        prep_next.op     = in_data.c.op;
        prep_next.v      = in_data.c.v;
        prep_next.res    = in_data.c.res;
        prep_next.len    = in_data.len;
        prep_next.bypass = in_data.len <= ROOT_W'(length_epsilon);
        if (in_data.c.op == OP_LENGTH) begin
            if (in_data.len[ROOT_W-1]) begin
                prep_next.res.scalar = 32'sh7FFF_FFFF;
                prep_next.res.sat    = 1'b1;
            end else begin
                prep_next.res.scalar = in_data.len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_vld_reg <= 1'b0;
        end else if (adv_prep) begin
            prep_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_prep) begin
            prep_reg <= prep_next;
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= mag_word(in_data.c.v[i]);
            end
        end
    end

    // One quotient bit per stage, MSB first.
    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        localparam int J = FRAC_BITS - s;

        logic             vld_in;
        dvc_t             c_in;
        logic [RW-1:0]    rem_in [3];
        logic [NSTEP-1:0] q_in   [3];
        logic [RW-1:0]    dsh;

        if (s == 0) begin : g_first
            assign vld_in = prep_vld_reg;
            assign c_in   = prep_reg;
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_in[i] = RW'(mag_reg[i]) << FRAC_BITS;
                assign q_in[i]   = '0;
            end
        end else begin : g_rest
            assign vld_in = vld_reg[s-1];
            assign c_in   = c_reg[s-1];
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_in[i] = rem_reg[s-1][i];
                assign q_in[i]   = q_reg[s-1][i];
            end
        end

        assign dsh    = RW'(c_in.len) << J;
        assign adv[s] = !vld_reg[s] || adv[s+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (adv[s]) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[s]) begin
                c_reg[s] <= c_in;
                for (int i = 0; i < 3; i++) begin
                    if (rem_in[i] >= dsh) begin
                        rem_reg[s][i] <= rem_in[i] - dsh;
                        q_reg[s][i]   <= q_in[i] | (NSTEP'(1) << J);
                    end else begin
                        rem_reg[s][i] <= rem_in[i];
                        q_reg[s][i]   <= q_in[i];
                    end
                end
            end
        end
    end

    // Apply the signs and assemble the result.
    always_comb begin
        out_next = c_reg[NSTEP-1].res;
        for (int i = 0; i < 3; i++) begin
            qw[i] = 32'(q_reg[NSTEP-1][i]);
            if (c_reg[NSTEP-1].v[i][WORD_W-1]) begin
                qw[i] = -qw[i];
            end
        end
        unique case (c_reg[NSTEP-1].op) inside
            OP_NORMALIZE, OP_ORTHO: begin
                for (int i = 0; i < 3; i++) begin
                    out_next.r[i] = c_reg[NSTEP-1].bypass ? c_reg[NSTEP-1].v[i] : qw[i];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv_out) begin
            out_valid_reg <= vld_reg[NSTEP-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out) begin
            out_reg    <= out_next;
            out_op_reg <= c_reg[NSTEP-1].op;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks on the assembled result.
    `VFA_ASSERT_IMP(a_axis_only_largest, aclk, aresetn,
        out_valid_reg && (out_op_reg != OP_LARGEST), out_reg.axis == AXIS_X)
    `VFA_ASSERT_IMP(a_normalize_no_clip, aclk, aresetn,
        out_valid_reg && (out_op_reg == OP_NORMALIZE), !out_reg.sat)
    `VFA_ASSERT_IMP(a_vector_ops_no_scalar, aclk, aresetn,
        out_valid_reg && ((out_op_reg == OP_NORMALIZE) || (out_op_reg == OP_ORTHO)),
        out_reg.scalar == 32'sd0)
    `VFA_ASSERT_NXT(a_last_step_lands, aclk, aresetn,
        vld_reg[NSTEP-1] && adv_out, out_valid_reg)

endmodule

>>> design/vector3_fixed_point_alu_top.sv
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_top
// 3D vector unit in signed fixed point: add, sub, dot, cross, length,
// normalize, ortho, largest axis and scale, with saturation flag.
// Throughput: one beat per cycle while m_tready is high; each of the 32
// square-root and FRAC_BITS+1 divider stages is a pipeline register.
// Reset clears all valid bits and sets length_epsilon to 1.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_top #(
    parameter int FRAC_BITS = vfa_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration: length_epsilon.
    input  logic                             cfg_wr_en,
    input  logic [vfa_pkg::EPS_W-1:0]        cfg_wr_data,
    // Input beats.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z from the lowest bit up
    input  logic [vfa_pkg::IN_DATA_W-1:0]    s_tdata,
    // operation
    input  logic [vfa_pkg::OP_W-1:0]         s_tuser,
    // Result beats.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // r_x, r_y, r_z, scalar_out, axis_index, zero padding, lowest bit up
    output logic [vfa_pkg::OUT_DATA_W-1:0]   m_tdata,
    // saturated
    output logic [0:0]                       m_tuser
);
    import vfa_pkg::*;

    logic [EPS_W-1:0] eps_reg;
    item_t            item;

    logic             f_valid;
    logic             f_ready;
    front_t           f_data;
    logic             m_valid;
    logic             m_ready;
    mid_t             m_data;
    logic             r_valid;
    logic             r_ready;
    root_t            r_data;
    result_t          res;

    // Epsilon register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_wr_en) begin
            eps_reg <= cfg_wr_data;
        end
    end

    // Unpack the input beat.
    assign item.op = op_t'(s_tuser);
    assign item.a  = s_tdata[3*WORD_W-1:0];
    assign item.b  = s_tdata[6*WORD_W-1:3*WORD_W];

    vfa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (item),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    vfa_mult #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    vfa_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (m_valid),
        .in_ready  (m_ready),
        .in_data   (m_data),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_data  (r_data)
    );

    vfa_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .length_epsilon (eps_reg),
        .in_valid       (r_valid),
        .in_ready       (r_ready),
        .in_data        (r_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_data       (res)
    );

    // Pack the result beat.
    assign m_tdata = {6'b000000, res.axis, res.scalar, res.r[2], res.r[1], res.r[0]};
    assign m_tuser = res.sat;

endmodule
